// ----- rtl/core/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the button press classifier: transaction
// structs, configuration register indexes, reset values and event codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int CFG_BITS          = 16;
    localparam int CFG_INDEX_BITS    = 2;

    localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET      = 16'd50;
    localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET    = 16'd500;
    localparam logic [CFG_BITS-1:0] DOUBLE_WINDOW_RESET = 16'd300;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DEBOUNCE      = 2'd0,
        CFG_LONG_PRESS    = 2'd1,
        CFG_DOUBLE_WINDOW = 2'd2
    } cfg_index_t;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_SHORT  = 2'd1;
    localparam logic [1:0] EV_LONG   = 2'd2;
    localparam logic [1:0] EV_DOUBLE = 2'd3;

    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_POLL = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0] press_event;
        logic       button_held;
    } out_item_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] debounce_ms;
        logic [CFG_BITS-1:0] long_press_ms;
        logic [CFG_BITS-1:0] double_window_ms;
    } cfg_t;

    typedef struct packed {
        logic button_down;
        logic release_seen;
        logic press_handled;
        logic awaiting_second;
    } flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/button_press_classifier.sv -----
// ----------------------------------------------------------------------------
// button_press_classifier
// path: an input transaction passes the input register, then the result register
// throughput: one transaction per cycle while out_stall is low, set by the input and result registers
// reset: async active low; config returns to 50/500/300 ms, button released,
// no press pending, all timestamps zero, both pipeline registers empty
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_classifier #(
    parameter int TIME_BITS = bpc_pkg::TIME_BITS_DEFAULT
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write,
    input  wire  [bpc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire  [bpc_pkg::CFG_BITS-1:0]         cfg_data,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  var bpc_pkg::in_item_t                in_item,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output bpc_pkg::out_item_t                   out_item
);

    bpc_pkg::cfg_t        cfg_reg;
    bpc_pkg::in_item_t    in_item_reg;
    logic                 in_valid_reg;
    logic                 in_valid_next;
    bpc_pkg::out_item_t   out_item_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    bpc_pkg::flags_t      flags_reg;
    bpc_pkg::flags_t      flags_next;
    logic [TIME_BITS-1:0] last_edge_time_reg;
    logic [TIME_BITS-1:0] last_edge_time_next;
    logic [TIME_BITS-1:0] press_time_reg;
    logic [TIME_BITS-1:0] press_time_next;
    logic [TIME_BITS-1:0] first_click_time_reg;
    logic [TIME_BITS-1:0] first_click_time_next;
    bpc_pkg::out_item_t   result;
    logic                 advance;
    logic                 take_in;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms      <= bpc_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ms    <= bpc_pkg::LONG_PRESS_RESET;
            cfg_reg.double_window_ms <= bpc_pkg::DOUBLE_WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bpc_pkg::CFG_DEBOUNCE:      cfg_reg.debounce_ms      <= cfg_data;
                bpc_pkg::CFG_LONG_PRESS:    cfg_reg.long_press_ms    <= cfg_data;
                bpc_pkg::CFG_DOUBLE_WINDOW: cfg_reg.double_window_ms <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // pipeline handshake
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next  = take_in || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    bpc_classify #(
        .TIME_BITS (TIME_BITS)
    ) u_classify (
        .cfg                   (cfg_reg),
        .item                  (in_item_reg),
        .flags                 (flags_reg),
        .last_edge_time        (last_edge_time_reg),
        .press_time            (press_time_reg),
        .first_click_time      (first_click_time_reg),
        .flags_next            (flags_next),
        .last_edge_time_next   (last_edge_time_next),
        .press_time_next       (press_time_next),
        .first_click_time_next (first_click_time_next),
        .result                (result)
    );

    // tracking state, updated as each transaction leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg.button_down     <= 1'b0;
            flags_reg.release_seen    <= 1'b0;
            flags_reg.press_handled   <= 1'b1;
            flags_reg.awaiting_second <= 1'b0;
            last_edge_time_reg        <= '0;
            press_time_reg            <= '0;
            first_click_time_reg      <= '0;
        end
        else if (advance)
        begin
            flags_reg            <= flags_next;
            last_edge_time_reg   <= last_edge_time_next;
            press_time_reg       <= press_time_next;
            first_click_time_reg <= first_click_time_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bpc_classify.sv -----
// ----------------------------------------------------------------------------
// bpc_classify
// Single-pass classification logic: debounces button edges, classifies polls
// as short, long or double press and computes the next tracking state.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_classify #(
    parameter int TIME_BITS = bpc_pkg::TIME_BITS_DEFAULT
) (
    input  var bpc_pkg::cfg_t      cfg,
    input  var bpc_pkg::in_item_t  item,
    input  var bpc_pkg::flags_t    flags,
    input  wire  [TIME_BITS-1:0]   last_edge_time,
    input  wire  [TIME_BITS-1:0]   press_time,
    input  wire  [TIME_BITS-1:0]   first_click_time,
    output bpc_pkg::flags_t        flags_next,
    output logic [TIME_BITS-1:0]   last_edge_time_next,
    output logic [TIME_BITS-1:0]   press_time_next,
    output logic [TIME_BITS-1:0]   first_click_time_next,
    output bpc_pkg::out_item_t     result
);

    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS-1:0] edge_gap;
    logic [TIME_BITS-1:0] held;
    logic [TIME_BITS-1:0] click_gap;
    logic                 edge_ok;
    logic                 long_hit;
    logic                 in_window;
    logic [1:0]           ev;

    assign t         = item.time_ms[TIME_BITS-1:0];
    assign edge_gap  = t - last_edge_time;
    assign held      = t - press_time;
    assign click_gap = t - first_click_time;
    assign edge_ok   = edge_gap >= TIME_BITS'(cfg.debounce_ms);
    assign long_hit  = held >= TIME_BITS'(cfg.long_press_ms);
    assign in_window = click_gap <= TIME_BITS'(cfg.double_window_ms);

    always_comb
    begin
        flags_next            = flags;
        last_edge_time_next   = last_edge_time;
        press_time_next       = press_time;
        first_click_time_next = first_click_time;
        ev                    = bpc_pkg::EV_NONE;

        if (item.func == bpc_pkg::FUNC_EDGE)
        begin
            if (edge_ok)
            begin
                last_edge_time_next = t;
                if (!flags.button_down)
                begin
                    press_time_next          = t;
                    flags_next.button_down   = 1'b1;
                    flags_next.release_seen  = 1'b0;
                    flags_next.press_handled = 1'b0;
                end
                else
                begin
                    flags_next.button_down  = 1'b0;
                    flags_next.release_seen = 1'b1;
                end
            end
        end
        else
        begin
            if (!flags.press_handled)
            begin
                if (flags.button_down && long_hit)
                begin
                    ev                       = bpc_pkg::EV_LONG;
                    flags_next.press_handled = 1'b1;
                end
                if (flags.release_seen)
                begin
                    if (!long_hit)
                    begin
                        if (flags.awaiting_second && in_window)
                        begin
                            ev                         = bpc_pkg::EV_DOUBLE;
                            flags_next.awaiting_second = 1'b0;
                            flags_next.press_handled   = 1'b1;
                        end
                        else if (!flags.awaiting_second)
                        begin
                            flags_next.awaiting_second = 1'b1;
                            first_click_time_next      = t;
                            flags_next.press_handled   = 1'b1;
                        end
                    end
                    else
                    begin
                        ev                       = bpc_pkg::EV_LONG;
                        flags_next.press_handled = 1'b1;
                    end
                end
            end
            // window ran out on an earlier first click
            if (flags.awaiting_second && !in_window)
            begin
                ev                         = bpc_pkg::EV_SHORT;
                flags_next.press_handled   = 1'b1;
                flags_next.awaiting_second = 1'b0;
            end
        end
    end

    assign result.press_event = ev;
    assign result.button_held = flags_next.button_down;

endmodule

`default_nettype wire

// ----- rtl/core/bpc_checker.sv -----
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks for the button press classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                in_valid,
    input wire                in_stall,
    input var bpc_pkg::in_item_t  in_item,
    input wire                out_valid,
    input wire                out_stall,
    input var bpc_pkg::out_item_t out_item
);

    // stalled input transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input changed");

    // stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

    // input only backs up when the result register is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result register");

    // a double press is always reported with the button released
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.press_event == bpc_pkg::EV_DOUBLE) |-> !out_item.button_held)
    else $error("double press reported while held");

    // no result right after reset
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button press classifier. A queue of edge and
// poll transactions feeds a driver with random gaps. Every accepted
// transaction runs through a cycle-free copy of the press logic, and the
// monitor compares each result against the oldest prediction. Stimulus runs
// through several register settings: directed corner cases first, then
// click trains with timing near the thresholds, bounces, wrap and noise.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 100;
    localparam int PHASE_ITEMS   = 180;
    localparam int PHASE_COUNT   = 8;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_REPORTS   = 50;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               cfg_write = 1'b0;
    logic [bpc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [bpc_pkg::CFG_BITS-1:0]       cfg_data  = '0;
    logic                               in_valid  = 1'b0;
    logic                               in_stall;
    bpc_pkg::in_item_t                  in_item   = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    bpc_pkg::out_item_t                 out_item;

    button_press_classifier i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // predicted block state
    bpc_pkg::cfg_t cfg_model    = '{bpc_pkg::DEBOUNCE_RESET, bpc_pkg::LONG_PRESS_RESET,
                                    bpc_pkg::DOUBLE_WINDOW_RESET};
    logic        btn_down       = 1'b0;
    logic        btn_released   = 1'b0;
    logic        press_done     = 1'b1;
    logic        second_pending = 1'b0;
    logic [31:0] last_edge_ms   = '0;
    logic [31:0] press_start_ms = '0;
    logic [31:0] first_click_ms = '0;

    bpc_pkg::in_item_t  button_items [$];
    bpc_pkg::out_item_t awaited_events [$];
    bpc_pkg::out_item_t next_event;
    int          items_queued   = 0;
    int          items_accepted = 0;
    int          events_seen    = 0;
    int          mismatches     = 0;
    int unsigned cycle_count    = 0;
    logic [31:0] now_ms         = '0;

    int          tx_wait = 0;
    int          tx_sent = 0;
    bit          tx_calm = 1'b0;
    int          rx_wait = 0;
    bit          rx_calm = 1'b0;

    function automatic bpc_pkg::out_item_t classify_press(bpc_pkg::in_item_t it);
        bpc_pkg::out_item_t res;
        logic [31:0] t;
        logic [31:0] since_edge;
        logic [31:0] held;
        logic [31:0] since_click;
        logic        double_found;
        t            = it.time_ms;
        double_found = 1'b0;
        res.press_event = bpc_pkg::EV_NONE;
        if (it.func == bpc_pkg::FUNC_EDGE)
        begin
            since_edge = t - last_edge_ms;
            if (since_edge >= {16'd0, cfg_model.debounce_ms})
            begin
                last_edge_ms = t;
                if (!btn_down)
                begin
                    press_start_ms = t;
                    btn_down       = 1'b1;
                    btn_released   = 1'b0;
                    press_done     = 1'b0;
                end
                else
                begin
                    btn_down     = 1'b0;
                    btn_released = 1'b1;
                end
            end
        end
        else
        begin
            if (!press_done)
            begin
                held = t - press_start_ms;
                if (btn_down && held >= {16'd0, cfg_model.long_press_ms})
                begin
                    res.press_event = bpc_pkg::EV_LONG;
                    press_done      = 1'b1;
                end
                if (btn_released)
                begin
                    since_click = t - first_click_ms;
                    if (held < {16'd0, cfg_model.long_press_ms})
                    begin
                        if (second_pending
                            && since_click <= {16'd0, cfg_model.double_window_ms})
                        begin
                            second_pending  = 1'b0;
                            press_done      = 1'b1;
                            res.press_event = bpc_pkg::EV_DOUBLE;
                            double_found    = 1'b1;
                        end
                        else if (!second_pending)
                        begin
                            second_pending = 1'b1;
                            first_click_ms = t;
                            press_done     = 1'b1;
                        end
                    end
                    else
                    begin
                        res.press_event = bpc_pkg::EV_LONG;
                        press_done      = 1'b1;
                    end
                end
            end
            since_click = t - first_click_ms;
            if (!double_found && second_pending
                && since_click > {16'd0, cfg_model.double_window_ms})
            begin
                res.press_event = bpc_pkg::EV_SHORT;
                press_done      = 1'b1;
                second_pending  = 1'b0;
            end
        end
        res.button_held = btn_down;
        return res;
    endfunction

    task automatic queue_item(logic kind, logic [31:0] t);
        bpc_pkg::in_item_t it;
        it.func    = kind;
        it.time_ms = t;
        button_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [31:0] pick_near(logic [31:0] x);
        case ($urandom_range(0, 4))
            0:       return x - 1;
            1:       return x;
            2:       return x + 1;
            3:       return $urandom_range(0, x);
            default: return $urandom_range(x, 2 * x + 1);
        endcase
    endfunction

    function automatic logic [31:0] edge_gap();
        case ($urandom_range(0, 5))
            0:       return (cfg_model.debounce_ms == 0) ? 32'd0 : cfg_model.debounce_ms - 1;
            1:       return cfg_model.debounce_ms;
            default: return cfg_model.debounce_ms + $urandom_range(1, 30);
        endcase
    endfunction

    task automatic gen_clicks();
        int          clicks;
        logic [31:0] hold;
        clicks = $urandom_range(1, 3);
        repeat (clicks)
        begin
            now_ms += edge_gap();
            queue_item(bpc_pkg::FUNC_EDGE, now_ms);
            // contact bounce right after the press
            if ($urandom_range(0, 4) == 0)
                queue_item(bpc_pkg::FUNC_EDGE,
                           now_ms + $urandom_range(0, cfg_model.debounce_ms));
            case ($urandom_range(0, 4))
                0, 1:    hold = cfg_model.debounce_ms + $urandom_range(0, 30);
                2, 3:    hold = pick_near(cfg_model.long_press_ms);
                default: hold = $urandom_range(0, 2 * cfg_model.long_press_ms);
            endcase
            if ($urandom_range(0, 2) == 0)
                queue_item(bpc_pkg::FUNC_POLL, now_ms + pick_near(cfg_model.long_press_ms));
            now_ms += hold;
            queue_item(bpc_pkg::FUNC_EDGE, now_ms);
            if ($urandom_range(0, 3) != 0)
                queue_item(bpc_pkg::FUNC_POLL, now_ms + $urandom_range(0, 5));
        end
        repeat ($urandom_range(1, 3))
        begin
            now_ms += pick_near(cfg_model.double_window_ms);
            queue_item(bpc_pkg::FUNC_POLL, now_ms);
        end
    endtask

    task automatic gen_activity(int target);
        int start;
        start = items_queued;
        while (items_queued - start < target)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    repeat ($urandom_range(1, 6))
                        queue_item(1'($urandom_range(0, 1)), $urandom());
                end
                1:
                begin
                    // run across the counter wrap
                    now_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
                    gen_clicks();
                end
                default: gen_clicks();
            endcase
        end
    endtask

    task automatic write_reg(bpc_pkg::cfg_index_t idx, logic [bpc_pkg::CFG_BITS-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            bpc_pkg::CFG_DEBOUNCE:      cfg_model.debounce_ms      = value;
            bpc_pkg::CFG_LONG_PRESS:    cfg_model.long_press_ms    = value;
            bpc_pkg::CFG_DOUBLE_WINDOW: cfg_model.double_window_ms = value;
            default:                    ;
        endcase
    endtask

    task automatic drain();
        while (items_accepted != items_queued || awaited_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic flag_mismatch(string field, int want, int got);
        if (mismatches < MAX_REPORTS)
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                awaited_events.push_back(classify_press(in_item));
                items_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (button_items.size() > 0)
                begin
                    in_item  <= button_items.pop_front();
                    in_valid <= 1'b1;
                    if (tx_sent % 64 == 0)
                        tx_calm = ($urandom_range(0, 3) == 0);
                    tx_sent++;
                    tx_wait = tx_calm ? 0 : $urandom_range(0, 14);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_events.size() == 0)
                begin
                    flag_mismatch("unexpected transaction, press_event", -1,
                                  out_item.press_event);
                end
                else
                begin
                    next_event = awaited_events.pop_front();
                    if (out_item.press_event !== next_event.press_event)
                        flag_mismatch("press_event", next_event.press_event,
                                      out_item.press_event);
                    if (out_item.button_held !== next_event.button_held)
                        flag_mismatch("button_held", next_event.button_held,
                                      out_item.button_held);
                end
                events_seen++;
                // long hold-off so the block backs up into its input
                if (events_seen % 500 == 250)
                begin
                    rx_wait = LONG_HOLD;
                end
                else
                begin
                    if (events_seen % 64 == 0)
                        rx_calm = ($urandom_range(0, 3) == 0);
                    rx_wait = rx_calm ? 0 : $urandom_range(0, 14);
                end
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
            end
            out_stall <= (rx_wait > 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [bpc_pkg::CFG_BITS-1:0] deb;
        logic [bpc_pkg::CFG_BITS-1:0] lng;
        logic [bpc_pkg::CFG_BITS-1:0] win;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset settings 50/500/300
        queue_item(bpc_pkg::FUNC_POLL, 32'd0);
        queue_item(bpc_pkg::FUNC_EDGE, 32'd10);          // bounce against time zero
        queue_item(bpc_pkg::FUNC_EDGE, 32'd100);
        queue_item(bpc_pkg::FUNC_POLL, 32'd350);
        queue_item(bpc_pkg::FUNC_POLL, 32'd600);         // long exactly at threshold
        queue_item(bpc_pkg::FUNC_EDGE, 32'd700);
        queue_item(bpc_pkg::FUNC_EDGE, 32'd800);
        queue_item(bpc_pkg::FUNC_EDGE, 32'd900);
        queue_item(bpc_pkg::FUNC_POLL, 32'd905);
        queue_item(bpc_pkg::FUNC_POLL, 32'd1206);        // window just expired
        queue_item(bpc_pkg::FUNC_EDGE, 32'd1300);
        queue_item(bpc_pkg::FUNC_EDGE, 32'd1360);
        queue_item(bpc_pkg::FUNC_POLL, 32'd1365);
        queue_item(bpc_pkg::FUNC_EDGE, 32'd1420);
        queue_item(bpc_pkg::FUNC_EDGE, 32'd1480);
        queue_item(bpc_pkg::FUNC_POLL, 32'd1665);        // double at window edge
        queue_item(bpc_pkg::FUNC_EDGE, 32'd2000);
        queue_item(bpc_pkg::FUNC_EDGE, 32'd2060);
        queue_item(bpc_pkg::FUNC_POLL, 32'd2065);
        queue_item(bpc_pkg::FUNC_EDGE, 32'd2120);
        queue_item(bpc_pkg::FUNC_EDGE, 32'd2180);
        queue_item(bpc_pkg::FUNC_POLL, 32'd2366);        // second click too late
        queue_item(bpc_pkg::FUNC_EDGE, 32'd3000);
        queue_item(bpc_pkg::FUNC_EDGE, 32'd3600);
        queue_item(bpc_pkg::FUNC_POLL, 32'd3601);        // long on release
        queue_item(bpc_pkg::FUNC_EDGE, 32'hFFFF_FFF0);
        queue_item(bpc_pkg::FUNC_EDGE, 32'h0000_0040);   // across the wrap
        queue_item(bpc_pkg::FUNC_POLL, 32'hFFFF_FFFF);
        drain();

        now_ms = 32'd5000;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:
                begin
                    deb = 16'd50;    lng = 16'd500;   win = 16'd300;
                end
                1:
                begin
                    deb = 16'd0;     lng = 16'd1;     win = 16'd1;
                end
                2:
                begin
                    deb = 16'hFFFF;  lng = 16'hFFFF;  win = 16'hFFFF;
                end
                3:
                begin
                    deb = 16'd20;    lng = 16'd200;   win = 16'd150;
                end
                4:
                begin
                    deb = 16'd0;     lng = 16'hFFFF;  win = 16'd1;
                end
                default:
                begin
                    deb = 16'($urandom_range(0, 100));
                    lng = 16'($urandom_range(1, 1000));
                    win = 16'($urandom_range(1, 800));
                end
            endcase
            write_reg(bpc_pkg::CFG_DEBOUNCE, deb);
            write_reg(bpc_pkg::CFG_LONG_PRESS, lng);
            write_reg(bpc_pkg::CFG_DOUBLE_WINDOW, win);
            gen_activity(PHASE_ITEMS);
            drain();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/bpc_pkg.sv
rtl/core/bpc_classify.sv
rtl/core/button_press_classifier.sv
rtl/core/bpc_checker.sv
tb/tb_top.sv
